@@ hdl/bvs_pkg.sv @@
// Package for the battery voltage supervisor: field widths, register
// indexes, reset values and the records passed between pipeline stages.
// No dependencies.
package bvs_pkg;

  localparam int ADC_W      = 12;
  localparam int SUM_W      = 20;
  localparam int GAIN_W     = 24;
  localparam int MV_W       = 16;
  localparam int STREAK_W   = 4;
  localparam int PROD_W     = SUM_W + GAIN_W;
  localparam int FRAC_W     = 16;
  // Unsaturated quotient before the divide by the block length fits here.
  localparam int QUOT_W     = 24;
  localparam int DIV_W      = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Q16  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_MV   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_MV    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT = 4'd3;

  localparam logic [GAIN_W-1:0]   GAIN_RESET  = 24'd52815;
  localparam logic [MV_W-1:0]     WARN_RESET  = 16'd7000;
  localparam logic [MV_W-1:0]     OFF_RESET   = 16'd6600;
  localparam logic [STREAK_W-1:0] LIMIT_RESET = 4'd3;
  localparam logic [STREAK_W-1:0] STREAK_MAX  = 4'd15;

  typedef struct packed {
    logic [GAIN_W-1:0]   gain_q16;
    logic [MV_W-1:0]     warn_mv;
    logic [MV_W-1:0]     off_mv;
    logic [STREAK_W-1:0] low_limit;
  } cfg_t;

  // One item leaving the accumulator; sum is meaningful only on a block end.
  typedef struct packed {
    logic             blk;
    logic [SUM_W-1:0] sum;
  } block_t;

  // One item leaving the scaler; mv is meaningful only on a block end.
  typedef struct packed {
    logic            blk;
    logic [MV_W-1:0] mv;
  } volt_t;

endpackage

@@ hdl/bvs_accum.sv @@
// Sample accumulator: sums converter samples and marks the item that ends
// each block. Depends on bvs_pkg.
module bvs_accum #(
  parameter int unsigned SAMPLES = 200
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bvs_pkg::ADC_W-1:0]  adc_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bvs_pkg::block_t            out_blk
);

  localparam int CNT_W = $clog2(SAMPLES + 1);

  logic [bvs_pkg::SUM_W-1:0] sample_sum;
  logic [CNT_W-1:0]          sample_count;
  logic [bvs_pkg::SUM_W-1:0] sum_next;
  logic [CNT_W-1:0]          count_next;
  logic                      block_done;
  logic                      accept;

  assign in_ready   = !out_valid || out_ready;
  assign accept     = in_valid && in_ready;
  assign sum_next   = sample_sum + bvs_pkg::SUM_W'(adc_sample);
  assign count_next = sample_count + CNT_W'(1);
  assign block_done = count_next >= CNT_W'(SAMPLES);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      sample_sum   <= '0;
      sample_count <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (accept) begin
        sample_sum   <= block_done ? '0 : sum_next;
        sample_count <= block_done ? '0 : count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_blk.blk <= block_done;
      out_blk.sum <= sum_next;
    end
  end

endmodule

@@ hdl/bvs_scale.sv @@
// Three-stage scaler: sum times gain, drop the Q16 fraction, divide by the
// block length through a reciprocal with one correction, saturate.
// Depends on bvs_pkg.
module bvs_scale #(
  parameter int unsigned SAMPLES = 200
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bvs_pkg::block_t             in_blk,
  input  logic [bvs_pkg::GAIN_W-1:0]  gain_q16,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bvs_pkg::volt_t              out_volt
);

  localparam int QW  = bvs_pkg::QUOT_W;
  localparam int QFW = bvs_pkg::PROD_W - bvs_pkg::FRAC_W;
  localparam int MW  = QW + bvs_pkg::MV_W;
  localparam longint unsigned SAT_VAL   = longint'(SAMPLES) << bvs_pkg::FRAC_W;
  localparam longint unsigned RECIP_VAL = (64'd1 << QW) / SAMPLES;
  localparam logic [QFW-1:0] SAT_LIMIT = SAT_VAL[QFW-1:0];
  localparam logic [QW:0]    RECIP     = RECIP_VAL[QW:0];
  localparam logic [bvs_pkg::DIV_W-1:0] DIVISOR = bvs_pkg::DIV_W'(SAMPLES);

  // Product stage.
  logic                        p_valid;
  logic                        p_blk;
  logic [bvs_pkg::PROD_W-1:0]  p_prod;
  // Reciprocal stage.
  logic                        r_valid;
  logic                        r_blk;
  logic                        r_sat;
  logic [QW-1:0]               r_q;
  logic [MW-1:0]               r_m;

  logic                        p_adv;
  logic                        r_adv;
  logic                        o_adv;
  logic [QFW-1:0]              q_full;
  logic                        q_sat;
  logic [QW+QW:0]              m_full;
  logic [bvs_pkg::MV_W-1:0]    est;
  logic [QW-1:0]               est_times_n;
  logic [QW-1:0]               rem;
  logic                        fix;

  assign o_adv    = !out_valid || out_ready;
  assign r_adv    = !r_valid || o_adv;
  assign p_adv    = !p_valid || r_adv;
  assign in_ready = p_adv;

  assign q_full = p_prod[bvs_pkg::PROD_W-1:bvs_pkg::FRAC_W];
  assign q_sat  = q_full >= SAT_LIMIT;
  assign m_full = (QW+QW+1)'(q_full[QW-1:0]) * (QW+QW+1)'(RECIP);

  // The estimate is at most one below the true quotient, so the remainder
  // stays under twice the divisor and a single compare corrects it.
  assign est         = r_m[MW-1:QW];
  assign est_times_n = QW'(est) * QW'(DIVISOR);
  assign rem         = r_q - est_times_n;
  assign fix         = rem >= QW'(DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      r_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (p_adv) begin
        p_valid <= in_valid;
      end
      if (r_adv) begin
        r_valid <= p_valid;
      end
      if (o_adv) begin
        out_valid <= r_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_adv) begin
      p_blk  <= in_blk.blk;
      p_prod <= bvs_pkg::PROD_W'(in_blk.sum) * bvs_pkg::PROD_W'(gain_q16);
    end
    if (r_adv) begin
      r_blk <= p_blk;
      r_sat <= q_sat;
      r_q   <= q_full[QW-1:0];
      r_m   <= m_full[MW-1:0];
    end
    if (o_adv) begin
      out_volt.blk <= r_blk;
      out_volt.mv  <= r_sat ? '1 : est + bvs_pkg::MV_W'(fix);
    end
  end

endmodule

@@ hdl/bvs_status.sv @@
// Result stage: holds the latest voltage, warning flag, low streak and the
// sticky shutdown flag, and presents them as the result register.
// Depends on bvs_pkg.
module bvs_status (
  input  logic                          clk,
  input  logic                          rst,
  input  bvs_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bvs_pkg::volt_t                in_volt,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          average_valid,
  output logic [bvs_pkg::MV_W-1:0]      last_voltage,
  output logic                          warn_flag,
  output logic [bvs_pkg::STREAK_W-1:0]  low_streak,
  output logic                          shutdown_latched
);

  logic                         load;
  logic [bvs_pkg::STREAK_W-1:0] streak_next;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    streak_next = low_streak;
    if (in_volt.blk) begin
      if (in_volt.mv <= cfg.off_mv) begin
        if (low_streak != bvs_pkg::STREAK_MAX) begin
          streak_next = low_streak + 1'b1;
        end
      end else begin
        streak_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      average_valid    <= 1'b0;
      last_voltage     <= '0;
      warn_flag        <= 1'b0;
      low_streak       <= '0;
      shutdown_latched <= 1'b0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (load) begin
        average_valid <= in_volt.blk;
        low_streak    <= streak_next;
        if (in_volt.blk) begin
          last_voltage <= in_volt.mv;
          warn_flag    <= in_volt.mv < cfg.warn_mv;
        end
        // The shutdown check runs on every item, after any block update.
        if (streak_next >= cfg.low_limit) begin
          shutdown_latched <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/battery_voltage_supervisor_unit.sv @@
// Top level of the battery voltage supervisor: configuration registers and
// the accumulator, scaler and status stages. Depends on bvs_pkg, bvs_accum,
// bvs_scale and bvs_status.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   input    | in_valid, in_ready, adc_sample            | in
//   result   | out_valid, out_ready, average_valid,      | out
//            | voltage_mv, battery_warn, low_streak_out, |
//            | shutdown                                  |
//   config   | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// One item is accepted per cycle unless back-pressure from out_ready fills
// the stages; each result passes from its sample through the accumulator,
// three scaler stages and the status stage. Every stage has its own valid
// bit, so bubbles close up while the result register is stalled. Reset
// clears the sum, count, status and the sticky shutdown flag and loads the
// register defaults. Configuration writes are always ready.
module battery_voltage_supervisor_unit #(
  parameter int unsigned SAMPLES_PER_AVERAGE = 200
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bvs_pkg::ADC_W-1:0]       adc_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            average_valid,
  output logic [bvs_pkg::MV_W-1:0]        voltage_mv,
  output logic                            battery_warn,
  output logic [bvs_pkg::STREAK_W-1:0]    low_streak_out,
  output logic                            shutdown,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bvs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bvs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bvs_pkg::cfg_t   cfg;
  bvs_pkg::block_t acc_blk;
  bvs_pkg::volt_t  scl_volt;
  logic            acc_valid;
  logic            acc_ready;
  logic            scl_valid;
  logic            scl_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_q16  <= bvs_pkg::GAIN_RESET;
      cfg.warn_mv   <= bvs_pkg::WARN_RESET;
      cfg.off_mv    <= bvs_pkg::OFF_RESET;
      cfg.low_limit <= bvs_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bvs_pkg::REG_GAIN_Q16:  cfg.gain_q16  <= cfg_data[bvs_pkg::GAIN_W-1:0];
        bvs_pkg::REG_WARN_MV:   cfg.warn_mv   <= cfg_data[bvs_pkg::MV_W-1:0];
        bvs_pkg::REG_OFF_MV:    cfg.off_mv    <= cfg_data[bvs_pkg::MV_W-1:0];
        bvs_pkg::REG_LOW_LIMIT: cfg.low_limit <= cfg_data[bvs_pkg::STREAK_W-1:0];
        default: ;
      endcase
    end
  end

  bvs_accum #(
    .SAMPLES(SAMPLES_PER_AVERAGE)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .adc_sample (adc_sample),
    .out_valid  (acc_valid),
    .out_ready  (acc_ready),
    .out_blk    (acc_blk)
  );

  bvs_scale #(
    .SAMPLES(SAMPLES_PER_AVERAGE)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (acc_valid),
    .in_ready  (acc_ready),
    .in_blk    (acc_blk),
    .gain_q16  (cfg.gain_q16),
    .out_valid (scl_valid),
    .out_ready (scl_ready),
    .out_volt  (scl_volt)
  );

  bvs_status u_status (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .in_valid         (scl_valid),
    .in_ready         (scl_ready),
    .in_volt          (scl_volt),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .average_valid    (average_valid),
    .last_voltage     (voltage_mv),
    .warn_flag        (battery_warn),
    .low_streak       (low_streak_out),
    .shutdown_latched (shutdown)
  );

  // Once raised, shutdown holds until reset.
  a_shutdown_sticky: assert property (@(posedge clk) disable iff (rst)
    shutdown |=> shutdown)
    else $error("shutdown flag dropped without reset");

  // The streak only moves with a freshly loaded block result.
  a_streak_on_block: assert property (@(posedge clk) disable iff (rst)
    !$stable(low_streak_out) |-> (out_valid && average_valid))
    else $error("low streak changed without a block result");

  // The voltage only moves with a freshly loaded block result.
  a_voltage_on_block: assert property (@(posedge clk) disable iff (rst)
    !$stable(voltage_mv) |-> (out_valid && average_valid))
    else $error("voltage changed without a block result");

endmodule
